// ===== rtl/core/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the RPN stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

    localparam int VAL_W         = 48;
    localparam int DEPTH_DEF     = 128;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [2:0] {
        CMD_PUSH    = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_SUB     = 3'd2,
        CMD_MUL     = 3'd3,
        CMD_DIV     = 3'd4,
        CMD_MOD     = 3'd5,
        CMD_EOL     = 3'd6,
        CMD_UNKNOWN = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_DIV_ZERO = 3'd3,
        ST_MOD_ZERO = 3'd4,
        ST_UNKNOWN  = 3'd5,
        ST_OVERFLOW = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_DOWN,
        CELL_UP
    } cell_op_t;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP,
        STK_REPL
    } stk_op_t;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_MOD
    } alu_op_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIN,
        A_DONE
    } alu_state_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_POP
    } ctl_state_t;

    typedef struct packed {
        logic    start;
        logic    ack;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } alu_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpn_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// RPN calculator datapath: Q32.16 value stack held in a chain of cells.
//
//   channel | valid     | stall     | word
//   --------+-----------+-----------+---------------------------------
//   input   | in_valid  | in_stall  | command, operand
//   output  | out_valid | out_stall | status, line_value, value_valid
//
// Push, add, subtract, end of line, unknown and zero-divisor faults answer in the cycle after acceptance.
// Multiply runs in the shift-add loop of the shared unit.
// Divide and modulo run in the restoring divider.
// Modulo by zero with two operands takes an extra S_POP state for the second pop.
// Reset clears the stack count; cell contents stay undefined until pushed.
// A result waiting on out_stall holds the next finished word back.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_evaluator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH   = DEPTH_DEF,
    parameter int FRACTION_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [2:0]              command,
    input  wire logic signed [VAL_W-1:0] operand,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [2:0]                   status,
    output logic signed [VAL_W-1:0]      line_value,
    output logic                         value_valid
);

    localparam int W    = VAL_W;
    localparam int CNTW = $clog2(STACK_DEPTH + 1);
    localparam logic [W-1:0] NEG_ONE = ~(W'(1) << FRACTION_BITS) + W'(1);

    ctl_state_t      state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            empty_reg, empty_next;
    logic            out_valid_reg, out_valid_next;
    status_t         status_reg, status_next;
    logic [W-1:0]    line_reg, line_next;
    logic            vvalid_reg, vvalid_next;

    logic [W-1:0]    cell_val [STACK_DEPTH];
    cell_op_t        cell_op  [STACK_DEPTH];
    stk_op_t         stk_op;
    logic [W-1:0]    load_val;

    alu_req_t        alu_req;
    alu_rsp_t        alu_rsp;
    logic [W-1:0]    alu_res;

    logic            out_free, accept, has1, has2, full;
    logic [W-1:0]    a_val, b_val;
    logic [W:0]      sum;
    logic            sum_ovf;
    logic [W-1:0]    sum_sat;
    logic [CNTW-1:0] repl_count;

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            always_comb
            begin
                case (stk_op)
                    STK_PUSH: cell_op[i] = CELL_DOWN;
                    STK_POP:  cell_op[i] = CELL_UP;
                    STK_REPL: cell_op[i] = (i == 0) ? CELL_DOWN : CELL_UP;
                    default:  cell_op[i] = CELL_HOLD;
                endcase
            end

            rpn_cell u_cell (
                .clk    (clk),
                .op     (cell_op[i]),
                .up_val ((i == 0) ? load_val : cell_val[(i == 0) ? 0 : i - 1]),
                .dn_val (cell_val[(i == STACK_DEPTH - 1) ? i : i + 1]),
                .val    (cell_val[i])
            );
        end
    endgenerate

    rpn_alu #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a_val  (a_val),
        .b_val  (b_val),
        .rsp    (alu_rsp),
        .result (alu_res)
    );

    always_comb
    begin
        out_free   = !out_valid_reg || !out_stall;
        in_stall   = !((state_reg == S_IDLE) && out_free);
        accept     = in_valid && !in_stall;
        has1       = count_reg != '0;
        has2       = count_reg > CNTW'(1);
        full       = count_reg == CNTW'(STACK_DEPTH);
        b_val      = has1 ? cell_val[0] : NEG_ONE;
        a_val      = has2 ? cell_val[1] : NEG_ONE;
        repl_count = has2 ? (count_reg - CNTW'(1)) : CNTW'(1);

        if (cmd_t'(command) == CMD_SUB)
            sum = {a_val[W-1], a_val} - {b_val[W-1], b_val};
        else
            sum = {a_val[W-1], a_val} + {b_val[W-1], b_val};
        sum_ovf = sum[W] != sum[W-1];
        sum_sat = sum_ovf ? {sum[W], {(W-1){~sum[W]}}} : sum[W-1:0];

        state_next     = state_reg;
        count_next     = count_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        line_next      = line_reg;
        vvalid_next    = vvalid_reg;
        stk_op         = STK_HOLD;
        load_val       = operand;
        alu_req.start  = 1'b0;
        alu_req.ack    = 1'b0;
        alu_req.op     = ALU_MUL;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    line_next   = '0;
                    vvalid_next = 1'b0;
                    unique case (cmd_t'(command))
                        CMD_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                                status_next = ST_FULL;
                            else
                            begin
                                status_next = ST_OK;
                                stk_op      = STK_PUSH;
                                count_next  = count_reg + CNTW'(1);
                            end
                        end
                        CMD_ADD, CMD_SUB:
                        begin
                            out_valid_next = 1'b1;
                            stk_op         = STK_REPL;
                            load_val       = sum_sat;
                            count_next     = repl_count;
                            status_next    = !has2 ? ST_EMPTY : (sum_ovf ? ST_OVERFLOW : ST_OK);
                        end
                        CMD_MUL:
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_MUL;
                            empty_next    = !has2;
                            state_next    = S_WAIT;
                        end
                        CMD_DIV:
                        begin
                            if (has1 && (cell_val[0] == '0))
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_DIV_ZERO;
                                stk_op         = STK_POP;
                                count_next     = count_reg - CNTW'(1);
                            end
                            else
                            begin
                                alu_req.start = 1'b1;
                                alu_req.op    = ALU_DIV;
                                empty_next    = !has2;
                                state_next    = S_WAIT;
                            end
                        end
                        CMD_MOD:
                        begin
                            if (has1 && (cell_val[0] == '0))
                            begin
                                out_valid_next = 1'b1;
                                status_next    = has2 ? ST_MOD_ZERO : ST_EMPTY;
                                stk_op         = STK_POP;
                                count_next     = count_reg - CNTW'(1);
                                if (has2)
                                    state_next = S_POP;
                            end
                            else
                            begin
                                alu_req.start = 1'b1;
                                alu_req.op    = ALU_MOD;
                                empty_next    = !has2;
                                state_next    = S_WAIT;
                            end
                        end
                        CMD_EOL:
                        begin
                            out_valid_next = 1'b1;
                            line_next      = b_val;
                            vvalid_next    = 1'b1;
                            status_next    = has1 ? ST_OK : ST_EMPTY;
                            if (has1)
                            begin
                                stk_op     = STK_POP;
                                count_next = count_reg - CNTW'(1);
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            status_next    = ST_UNKNOWN;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                if (alu_rsp.done && out_free)
                begin
                    alu_req.ack    = 1'b1;
                    out_valid_next = 1'b1;
                    line_next      = '0;
                    vvalid_next    = 1'b0;
                    status_next    = empty_reg ? ST_EMPTY :
                                     (alu_rsp.ovf ? ST_OVERFLOW : ST_OK);
                    stk_op         = STK_REPL;
                    load_val       = alu_res;
                    count_next     = repl_count;
                    state_next     = S_IDLE;
                end
            end
            S_POP:
            begin
                stk_op     = STK_POP;
                count_next = count_reg - CNTW'(1);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        empty_reg  <= empty_next;
        status_reg <= status_next;
        line_reg   <= line_next;
        vvalid_reg <= vvalid_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign line_value  = line_reg;
    assign value_valid = vvalid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == S_WAIT))
        else $error("arithmetic unit done outside wait");

    a_pop_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |=> (state_reg == S_IDLE))
        else $error("extra pop did not return to idle");

    a_start_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |-> accept)
        else $error("arithmetic unit started without accepted word");

endmodule

`default_nettype wire

// ===== rtl/core/rpn_cell.sv =====
// ----------------------------------------------------------------------------
// rpn_cell
// One stack cell: holds a value or takes it from the neighbor above or below.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_cell
    import rpn_pkg::*;
(
    input  wire logic             clk,
    input  wire cell_op_t         op,
    input  wire logic [VAL_W-1:0] up_val,
    input  wire logic [VAL_W-1:0] dn_val,
    output logic      [VAL_W-1:0] val
);

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;

    always_comb
    begin
        case (op)
            CELL_DOWN: val_next = up_val;
            CELL_UP:   val_next = dn_val;
            default:   val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rpn_alu.sv =====
// ----------------------------------------------------------------------------
// rpn_alu
// Iterative fixed point unit: shift-add multiply, restoring divide, modulo.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_alu
    import rpn_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire alu_req_t         req,
    input  wire logic [VAL_W-1:0] a_val,
    input  wire logic [VAL_W-1:0] b_val,
    output alu_rsp_t              rsp,
    output logic      [VAL_W-1:0] result
);

    localparam int W  = VAL_W;
    localparam int DW = W + FRACTION_BITS;
    localparam int PW = 2 * W;
    localparam int MW = PW + 1;
    localparam int CW = $clog2(DW + 1);

    alu_state_t      state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    alu_op_t         op_reg, op_next;
    logic            a_neg_reg, a_neg_next;
    logic            b_neg_reg, b_neg_next;
    logic [W-1:0]    b_reg, b_next;
    logic [W-1:0]    ua_reg, ua_next;
    logic [W-1:0]    ub_reg, ub_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [PW-1:0]   prod_reg, prod_next;
    logic [W-1:0]    res_reg, res_next;
    logic            ovf_reg, ovf_next;

    logic [W-1:0]    ua_in, ub_in;
    logic [W:0]      rem_sh;
    logic            ge;
    logic [W:0]      hi_sum;
    logic            neg;
    logic            rest;
    logic [MW-1:0]   mag, lim;
    logic            over;
    logic [W-1:0]    r_mod;

    always_comb
    begin
        ua_in  = a_val[W-1] ? (~a_val + W'(1)) : a_val;
        ub_in  = b_val[W-1] ? (~b_val + W'(1)) : b_val;
        rem_sh = {rem_reg, quo_reg[DW-1]};
        ge     = rem_sh >= {1'b0, ub_reg};
        hi_sum = {1'b0, prod_reg[PW-1:W]} + (prod_reg[0] ? {1'b0, ua_reg} : (W+1)'(0));
        neg    = a_neg_reg ^ b_neg_reg;
        rest   = |(prod_reg & ~({PW{1'b1}} << FRACTION_BITS));
        if (op_reg == ALU_MUL)
            mag = MW'(prod_reg >> FRACTION_BITS) + MW'(neg && rest);
        else
            mag = MW'(quo_reg);
        lim    = neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
        over   = mag > lim;
        r_mod  = a_neg_reg ? (~rem_reg + W'(1)) : rem_reg;
        if ((rem_reg != '0) && (a_neg_reg != b_neg_reg))
            r_mod = r_mod + b_reg;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        a_neg_next = a_neg_reg;
        b_neg_next = b_neg_reg;
        b_next     = b_reg;
        ua_next    = ua_reg;
        ub_next    = ub_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        ovf_next   = ovf_reg;

        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    a_neg_next = a_val[W-1];
                    b_neg_next = b_val[W-1];
                    b_next     = b_val;
                    ua_next    = ua_in;
                    ub_next    = ub_in;
                    rem_next   = '0;
                    prod_next  = {{W{1'b0}}, ub_in};
                    if (req.op == ALU_MUL)
                    begin
                        cnt_next   = CW'(W);
                        state_next = A_MUL;
                    end
                    else
                    begin
                        cnt_next   = CW'(DW);
                        state_next = A_DIV;
                    end
                    if (req.op == ALU_DIV)
                        quo_next = {ua_in, {FRACTION_BITS{1'b0}}};
                    else
                        quo_next = DW'(ua_in);
                end
            end
            A_MUL:
            begin
                prod_next = {hi_sum, prod_reg[W-1:1]};
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    state_next = A_FIN;
            end
            A_DIV:
            begin
                rem_next = ge ? W'(rem_sh - {1'b0, ub_reg}) : rem_sh[W-1:0];
                quo_next = {quo_reg[DW-2:0], ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    state_next = A_FIN;
            end
            A_FIN:
            begin
                if (op_reg == ALU_MOD)
                begin
                    res_next = r_mod;
                    ovf_next = 1'b0;
                end
                else
                begin
                    ovf_next = over;
                    if (over)
                        res_next = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                    else
                        res_next = neg ? (~mag[W-1:0] + W'(1)) : mag[W-1:0];
                end
                state_next = A_DONE;
            end
            A_DONE:
            begin
                if (req.ack)
                    state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        a_neg_reg <= a_neg_next;
        b_neg_reg <= b_neg_next;
        b_reg     <= b_next;
        ua_reg    <= ua_next;
        ub_reg    <= ub_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
        ovf_reg   <= ovf_next;
    end

    assign rsp.done = (state_reg == A_DONE);
    assign rsp.ovf  = ovf_reg;
    assign result   = res_reg;

endmodule

`default_nettype wire
